// ----- hw/rtl/cpgs_pkg.sv -----
// Package with the types, constants and codes of the Coulomb potential grid sum block.
`timescale 1ns / 1ps
package cpgs_pkg;

    localparam int MAX_CENTERS = 64;
    localparam int IDX_W = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int CNT_W = $clog2(MAX_CENTERS + 1);

    localparam int POS_W = 32;
    localparam int Q_W = 16;
    localparam int POT_W = 48;
    localparam int STEP_W = 32;
    localparam int DIFF_W = POS_W + 1;
    localparam int SQ_W = 66;
    localparam int ACC_W = 64;
    localparam int DIV_W = 50;
    localparam int ROOT_W = 32;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS = DIV_W;
    localparam int CTR_W = $clog2(DIV_STEPS);

    localparam logic [SQ_W-1:0] NEAR_SQ_LIMIT = SQ_W'(429497);
    localparam logic [STEP_W-1:0] GRID_STEP_RESET = STEP_W'(65536);
    localparam logic signed [ACC_W-1:0] POT_MAX = ACC_W'(64'sd140737488355327);
    localparam logic signed [ACC_W-1:0] POT_MIN = -ACC_W'(64'sd140737488355328);

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_EVAL  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_SQ,
        S_TEST,
        S_SQRT,
        S_DIVI,
        S_DIV,
        S_ACC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic signed [Q_W-1:0]   q;
    } t_center;

    typedef struct packed {
        logic             mem_we;
        logic             mem_re;
        logic [IDX_W-1:0] mem_addr;
        logic             grab_point;
        logic             diff_en;
        logic [1:0]       sq_sel;
        logic             sq_add;
        logic             sqrt_init;
        logic             sqrt_step;
        logic             div_init;
        logic             div_step;
        logic             acc_clr;
        logic             acc_add;
        logic             out_load;
    } t_cmd;

    typedef struct packed {
        logic near;
        logic out_busy;
    } t_sts;

endpackage

// ----- hw/rtl/cpgs_intf.sv -----
// Valid/ready channel interfaces for the request and response words.
`timescale 1ns / 1ps
interface cpgs_req_if import cpgs_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              action;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [Q_W-1:0]   charge;

    modport source(output valid, action, pos_x, pos_y, pos_z, charge, input ready);
    modport sink(input valid, action, pos_x, pos_y, pos_z, charge, output ready);
endinterface

interface cpgs_rsp_if import cpgs_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [POT_W-1:0] potential;
    logic                    saturated;

    modport source(output valid, potential, saturated, input ready);
    modport sink(input valid, potential, saturated, output ready);
endinterface

// ----- hw/rtl/cpgs_ctrl.sv -----
// Controller state machine that sequences center loads and potential evaluation.
`timescale 1ns / 1ps
module cpgs_ctrl import cpgs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cpgs_req_if.sink   i_req,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CTR_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        i_req.ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    case (t_action'(i_req.action))
                        ACT_CLEAR: begin
                            n_count = '0;
                        end
                        ACT_LOAD: begin
                            if (r_count < CNT_W'(MAX_CENTERS)) begin
                                o_cmd.mem_we   = 1'b1;
                                o_cmd.mem_addr = r_count[IDX_W-1:0];
                                n_count        = CNT_W'(r_count + 1'b1);
                            end
                        end
                        ACT_EVAL: begin
                            o_cmd.grab_point = 1'b1;
                            o_cmd.acc_clr    = 1'b1;
                            n_idx            = '0;
                            if (r_count == '0) begin
                                n_state = S_DONE;
                            end else begin
                                o_cmd.mem_re   = 1'b1;
                                o_cmd.mem_addr = '0;
                                n_state        = S_DIFF;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIFF: begin
                o_cmd.diff_en = 1'b1;
                n_cnt         = '0;
                n_state       = S_SQ;
            end
            S_SQ: begin
                o_cmd.sq_sel = r_cnt[1:0];
                o_cmd.sq_add = (r_cnt != '0);
                if (r_cnt == CTR_W'(3)) begin
                    n_cnt   = '0;
                    n_state = S_TEST;
                end else begin
                    n_cnt = CTR_W'(r_cnt + 1'b1);
                end
            end
            S_TEST: begin
                n_cnt = '0;
                if (i_sts.near) begin
                    n_state = S_DIVI;
                end else begin
                    o_cmd.sqrt_init = 1'b1;
                    n_state         = S_SQRT;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_cnt == CTR_W'(SQRT_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DIVI;
                end else begin
                    n_cnt = CTR_W'(r_cnt + 1'b1);
                end
            end
            S_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CTR_W'(DIV_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_ACC;
                end else begin
                    n_cnt = CTR_W'(r_cnt + 1'b1);
                end
            end
            S_ACC: begin
                o_cmd.acc_add = 1'b1;
                n_idx         = CNT_W'(r_idx + 1'b1);
                if (n_idx == r_count) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.mem_re   = 1'b1;
                    o_cmd.mem_addr = n_idx[IDX_W-1:0];
                    n_state        = S_DIFF;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_CENTERS))
        else $error("Center count exceeds capacity.");

    a_idx_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIFF) |-> (r_idx < r_count))
        else $error("Center index reached the center count while evaluating.");

    a_sqrt_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT && r_cnt == CTR_W'(SQRT_STEPS - 1)) |=> (r_state == S_DIVI))
        else $error("Square root did not hand over to the divider.");

endmodule

// ----- hw/rtl/cpgs_datapath.sv -----
// Datapath with the center memory, distance, square root, divider and accumulator.
`timescale 1ns / 1ps
module cpgs_datapath import cpgs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [STEP_W-1:0]   i_cfg_wdata,
    cpgs_req_if.sink            i_req,
    cpgs_rsp_if.source          o_rsp,
    input  t_cmd                i_cmd,
    output t_sts                o_sts
);

    t_center                 r_mem [MAX_CENTERS];
    t_center                 r_rd;
    logic [STEP_W-1:0]       r_grid_step;
    logic signed [POS_W-1:0] r_gx, r_gy, r_gz;
    logic [DIFF_W-1:0]       r_dx, r_dy, r_dz;
    logic signed [Q_W-1:0]   r_q;
    logic [SQ_W-1:0]         r_prod, r_s;
    logic [63:0]             r_v;
    logic [ROOT_W+2:0]       r_rem;
    logic [ROOT_W-1:0]       r_root;
    logic [DIV_W-1:0]        r_num;
    logic [STEP_W-1:0]       r_drem, r_dvs;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_out_valid;
    logic signed [POT_W-1:0] r_pot;
    logic                    r_sat;

    logic [DIFF_W-1:0]       sq_in;
    logic                    near;
    logic [Q_W-1:0]          qa;
    logic [ROOT_W+2:0]       rem_sh, trial;
    logic [STEP_W:0]         dtry;
    logic                    dge;
    logic signed [ACC_W-1:0] mag_x;

    function automatic logic [DIFF_W-1:0] abs_diff(logic signed [POS_W-1:0] a,
                                                   logic signed [POS_W-1:0] b);
        logic signed [DIFF_W-1:0] d;
        d = DIFF_W'(a) - DIFF_W'(b);
        return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_mem[i_cmd.mem_addr] <= '{i_req.pos_x, i_req.pos_y, i_req.pos_z, i_req.charge};
        end
        if (i_cmd.mem_re) begin
            r_rd <= r_mem[i_cmd.mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_step <= GRID_STEP_RESET;
        end else if (i_cfg_we) begin
            r_grid_step <= i_cfg_wdata;
        end
    end

    always_comb begin
        case (i_cmd.sq_sel)
            2'd0:    sq_in = r_dx;
            2'd1:    sq_in = r_dy;
            default: sq_in = r_dz;
        endcase
        near   = (r_s < NEAR_SQ_LIMIT);
        qa     = r_q[Q_W-1] ? Q_W'(-r_q) : Q_W'(r_q);
        rem_sh = {r_rem[ROOT_W:0], r_v[63:62]};
        trial  = {1'b0, r_root, 2'b01};
        dtry   = {r_drem, r_num[DIV_W-1]};
        dge    = (dtry >= {1'b0, r_dvs});
        mag_x  = ACC_W'(r_num);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.grab_point) begin
            r_gx <= i_req.pos_x;
            r_gy <= i_req.pos_y;
            r_gz <= i_req.pos_z;
        end
        if (i_cmd.diff_en) begin
            r_dx <= abs_diff(r_gx, r_rd.x);
            r_dy <= abs_diff(r_gy, r_rd.y);
            r_dz <= abs_diff(r_gz, r_rd.z);
            r_q  <= r_rd.q;
            r_s  <= '0;
        end else if (i_cmd.sq_add) begin
            r_s <= r_s + r_prod;
        end
        r_prod <= SQ_W'(sq_in) * SQ_W'(sq_in);
        if (i_cmd.sqrt_init) begin
            r_v    <= r_s[SQ_W-1:2];
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_v <= {r_v[61:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.div_init) begin
            r_drem <= '0;
            if (near) begin
                r_num <= {(Q_W + 2)'({qa, 1'b0}) + (Q_W + 2)'(qa), 32'd0};
                r_dvs <= (r_grid_step == '0) ? STEP_W'(1) : r_grid_step;
            end else begin
                r_num <= DIV_W'({qa, 31'd0});
                r_dvs <= r_root;
            end
        end else if (i_cmd.div_step) begin
            r_drem <= dge ? STEP_W'(dtry - {1'b0, r_dvs}) : dtry[STEP_W-1:0];
            r_num  <= {r_num[DIV_W-2:0], dge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_q[Q_W-1] ? r_acc + mag_x : r_acc - mag_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_acc > POT_MAX) begin
                r_pot <= POT_MAX[POT_W-1:0];
                r_sat <= 1'b1;
            end else if (r_acc < POT_MIN) begin
                r_pot <= POT_MIN[POT_W-1:0];
                r_sat <= 1'b1;
            end else begin
                r_pot <= r_acc[POT_W-1:0];
                r_sat <= 1'b0;
            end
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.potential = r_pot;
    assign o_rsp.saturated = r_sat;
    assign o_sts.near      = near;
    assign o_sts.out_busy  = r_out_valid;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !r_out_valid)
        else $error("Result loaded over a pending word.");

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_dvs != '0))
        else $error("Divider started with a zero divisor.");

    a_sqrt_not_near: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sqrt_init |-> !near)
        else $error("Square root started for a near center.");

endmodule

// ----- hw/rtl/coulomb_potential_grid_sum.sv -----
// Top level of the Coulomb potential grid sum block.
`timescale 1ns / 1ps
// Clear and load words are handled in the idle state. An evaluate word steps
// through the stored centers one after another, each through the bit-serial
// square root (skipped for a center closer than 0.01) and the bit-serial
// divider, which all centers share. The result word waits in an output register,
// and the next request word is taken while it waits.
module coulomb_potential_grid_sum import cpgs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [STEP_W-1:0]   i_cfg_wdata,
    cpgs_req_if.sink            i_req,
    cpgs_rsp_if.source          o_rsp
);

    t_cmd cmd;
    t_sts sts;

    cpgs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    cpgs_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for the Coulomb potential grid sum block: directed table, then random words.
`timescale 1ns / 1ps
module tb;
    import cpgs_pkg::*;

    typedef struct {
        logic signed [POT_W-1:0] pot;
        logic                    sat;
    } t_potential;

    typedef struct {
        t_action                 act;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic signed [Q_W-1:0]   q;
        bit                      typed;
        logic signed [POT_W-1:0] pot;
        logic                    sat;
    } t_vec;

    localparam logic signed [POS_W-1:0] PMAX = 32'sh7FFFFFFF;
    localparam logic signed [POS_W-1:0] PMIN = 32'sh80000000;
    localparam longint SAT_HI = 64'sd140737488355327;
    localparam longint SAT_LO = -64'sd140737488355328;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [STEP_W-1:0] i_cfg_wdata;

    cpgs_req_if req ();
    cpgs_rsp_if rsp ();

    coulomb_potential_grid_sum dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req),
        .o_rsp       (rsp)
    );

    always #1 i_clk = ~i_clk;

    logic signed [POS_W-1:0] cx [MAX_CENTERS];
    logic signed [POS_W-1:0] cy [MAX_CENTERS];
    logic signed [POS_W-1:0] cz [MAX_CENTERS];
    logic signed [Q_W-1:0]   cq [MAX_CENTERS];
    int unsigned             n_centers;
    logic [STEP_W-1:0]       step_reg;
    t_potential              pending_pots [$];
    int                      mismatches;
    bit                      idle_on;
    int                      stall_left;

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic t_potential grid_potential(logic signed [POS_W-1:0] gx,
                                                  logic signed [POS_W-1:0] gy,
                                                  logic signed [POS_W-1:0] gz);
        t_potential  r;
        longint      sum;
        longint      dx, dy, dz, qs;
        logic [65:0] s;
        logic [63:0] qa, mag, stp, root;
        sum = 0;
        for (int i = 0; i < n_centers; i++) begin
            dx = longint'(gx) - longint'(cx[i]);
            dy = longint'(gy) - longint'(cy[i]);
            dz = longint'(gz) - longint'(cz[i]);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            if (dz < 0) dz = -dz;
            s = 66'(64'(dx) * 64'(dx)) + 66'(64'(dy) * 64'(dy)) + 66'(64'(dz) * 64'(dz));
            qs = longint'(cq[i]);
            qa = (qs < 0) ? 64'(-qs) : 64'(qs);
            if (s < NEAR_SQ_LIMIT) begin
                stp = (step_reg == 0) ? 64'd1 : 64'(step_reg);
                mag = ((qa * 3) << 32) / stp;
            end else begin
                root = int_sqrt(64'(s >> 2));
                mag = (qa << 31) / root;
            end
            sum = (qs < 0) ? sum + longint'(mag) : sum - longint'(mag);
        end
        r.sat = 1'b0;
        if (sum > SAT_HI) begin
            sum = SAT_HI;
            r.sat = 1'b1;
        end else if (sum < SAT_LO) begin
            sum = SAT_LO;
            r.sat = 1'b1;
        end
        r.pot = sum[POT_W-1:0];
        return r;
    endfunction

    task automatic send_word(t_action act, logic signed [POS_W-1:0] x,
                             logic signed [POS_W-1:0] y, logic signed [POS_W-1:0] z,
                             logic signed [Q_W-1:0] q, bit typed = 0,
                             logic signed [POT_W-1:0] tpot = 0, logic tsat = 0);
        t_potential p;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        req.valid  <= 1'b1;
        req.action <= act;
        req.pos_x  <= x;
        req.pos_y  <= y;
        req.pos_z  <= z;
        req.charge <= q;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        case (act)
            ACT_CLEAR: n_centers = 0;
            ACT_LOAD: begin
                if (n_centers < MAX_CENTERS) begin
                    cx[n_centers] = x;
                    cy[n_centers] = y;
                    cz[n_centers] = z;
                    cq[n_centers] = q;
                    n_centers++;
                end
            end
            ACT_EVAL: begin
                if (typed) begin
                    p.pot = tpot;
                    p.sat = tsat;
                end else begin
                    p = grid_potential(x, y, z);
                end
                pending_pots = {pending_pots, p};
            end
            default: ;
        endcase
    endtask

    task automatic drain_results();
        req.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pots.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_step(logic [STEP_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        step_reg = v;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_potential e;
        if (rsp.valid && rsp.ready) begin
            if (pending_pots.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word: potential %0d saturated %0b",
                             rsp.potential, rsp.saturated);
            end else begin
                e = pending_pots.pop_front();
                if (rsp.potential !== e.pot || rsp.saturated !== e.sat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %0d/%0b, got %0d/%0b",
                                 e.pot, e.sat, rsp.potential, rsp.saturated);
                end
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp.ready  <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 4);
            rsp.ready  <= 1'b0;
        end else begin
            rsp.ready <= 1'b1;
        end
    end

    initial begin
        #100000000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic signed [POS_W-1:0] rand_pos(logic signed [POS_W-1:0] base);
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return ($urandom_range(0, 1) != 0) ? PMAX : PMIN;
            2, 3: return base + $signed(32'($urandom_range(0, 1400)) - 32'sd700);
            default: return base + $signed(32'($urandom_range(0, 2 ** 20)) - 32'sd524288);
        endcase
    endfunction

    function automatic logic signed [Q_W-1:0] rand_charge();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            default: return Q_W'($urandom);
        endcase
    endfunction

    t_vec table_vecs [] = '{
        '{ACT_EVAL,  0, 0, 0, 0, 1, 0, 0},
        '{ACT_NONE,  PMAX, PMIN, PMAX, 16'sh7FFF, 0, 0, 0},
        '{ACT_LOAD,  0, 0, 0, 256, 0, 0, 0},
        '{ACT_EVAL,  0, 0, 0, 0, 1, -48'sd50331648, 0},
        '{ACT_EVAL,  65536, 0, 0, 0, 1, -48'sd16777216, 0},
        '{ACT_EVAL,  655, 0, 0, 0, 1, -48'sd50331648, 0},
        '{ACT_EVAL,  656, 0, 0, 0, 0, 0, 0},
        '{ACT_EVAL,  0, -655, 0, 0, 1, -48'sd50331648, 0},
        '{ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0},
        '{ACT_EVAL,  PMAX, PMAX, PMAX, 0, 1, 0, 0},
        '{ACT_LOAD,  PMAX, PMAX, PMAX, 16'sh8000, 0, 0, 0},
        '{ACT_LOAD,  PMIN, PMIN, PMIN, 16'sh7FFF, 0, 0, 0},
        '{ACT_LOAD,  PMAX, PMIN, 0, -1, 0, 0, 0},
        '{ACT_LOAD,  100, -200, 300, 0, 0, 0, 0},
        '{ACT_EVAL,  PMIN, PMAX, PMIN, 0, 0, 0, 0},
        '{ACT_EVAL,  PMAX, PMAX, PMAX, 0, 0, 0, 0},
        '{ACT_EVAL,  PMIN, PMIN, PMIN, 0, 0, 0, 0},
        '{ACT_EVAL,  100, -200, 300, 0, 0, 0, 0},
        '{ACT_NONE,  0, 0, 0, 0, 0, 0, 0},
        '{ACT_EVAL,  0, 0, 0, 0, 0, 0, 0}
    };

    logic [STEP_W-1:0] step_list [5] = '{32'd0, 32'd66, 32'hFFFFFFFF, 32'd65536, 32'd0};

    initial begin
        int                      sent;
        int                      k;
        int                      j;
        logic signed [POS_W-1:0] bx, by, bz;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        req.valid    = 1'b0;
        req.action   = ACT_CLEAR;
        req.pos_x    = '0;
        req.pos_y    = '0;
        req.pos_z    = '0;
        req.charge   = '0;
        rsp.ready    = 1'b0;
        n_centers    = 0;
        step_reg     = GRID_STEP_RESET;
        mismatches   = 0;
        idle_on      = 1'b1;
        stall_left   = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_vecs[i])
            send_word(table_vecs[i].act, table_vecs[i].x, table_vecs[i].y, table_vecs[i].z,
                      table_vecs[i].q, table_vecs[i].typed, table_vecs[i].pot,
                      table_vecs[i].sat);
        drain_results();

        step_list[4] = $urandom_range(66, 32'hFFFFFFFF);
        sent = 0;
        for (int ph = 0; ph < 5; ph++) begin
            write_step(step_list[ph]);
            while (sent < 370 * (ph + 1)) begin
                if (ph == 4 && sent > 1650) idle_on = 1'b0;
                bx = $urandom_range(0, 1) ? 32'($urandom) : 32'($urandom_range(0, 2 ** 22));
                by = $urandom;
                bz = $urandom;
                send_word(ACT_CLEAR, $urandom, $urandom, $urandom, Q_W'($urandom));
                k = ($urandom_range(0, 40) == 0) ? $urandom_range(64, 67)
                                                 : $urandom_range(0, 8);
                for (int c = 0; c < k; c++)
                    send_word(ACT_LOAD, rand_pos(bx), rand_pos(by), rand_pos(bz),
                              rand_charge());
                sent += k + 1;
                for (int e = $urandom_range(1, 5); e > 0; e--) begin
                    if (n_centers != 0 && $urandom_range(0, 2) == 0) begin
                        j = $urandom_range(0, n_centers - 1);
                        send_word(ACT_EVAL, cx[j] + $signed(32'($urandom_range(0, 8)) - 4),
                                  cy[j], cz[j] + $signed(32'($urandom_range(0, 1300)) - 650),
                                  Q_W'($urandom));
                    end else if ($urandom_range(0, 15) == 0) begin
                        send_word(ACT_NONE, $urandom, $urandom, $urandom, Q_W'($urandom));
                    end else begin
                        send_word(ACT_EVAL, rand_pos(bx), rand_pos(by), rand_pos(bz),
                                  Q_W'($urandom));
                    end
                    sent++;
                end
            end
            drain_results();
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_pots.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
